FILE: rtl/tftpp_pkg.sv
// Shared types, codes and constants for the TFTP packet parser.
package tftpp_pkg;

    typedef enum logic [2:0] {
        ROLE_OPCODE   = 3'd0,
        ROLE_NUMBER   = 3'd1,
        ROLE_FILENAME = 3'd2,
        ROLE_MODE     = 3'd3,
        ROLE_PAYLOAD  = 3'd4,
        ROLE_MESSAGE  = 3'd5,
        ROLE_TERM     = 3'd6,
        ROLE_IGNORED  = 3'd7
    } t_role;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_RRQ     = 3'd1,
        KIND_WRQ     = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_ACK     = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_OPCODE   = 3'd2,
        ST_FNAME_UNTERM = 3'd3,
        ST_MODE_UNTERM  = 3'd4,
        ST_MODE_UNKNOWN = 3'd5,
        ST_ACK_LEN      = 3'd6,
        ST_MSG_UNTERM   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        SEC_FIRST = 2'd0,
        SEC_MODE  = 2'd1,
        SEC_DONE  = 2'd2
    } t_section;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  byte_out;
        t_role       byte_role;
        t_kind       packet_kind;
        logic [15:0] number_value;
        logic        transfer_mode;
        logic        packet_done;
        t_status     status;
    } t_out_word;

    localparam logic [2:0] MinReqLen   = 3'd6;
    localparam logic [2:0] MinErrLen   = 3'd5;
    localparam logic [2:0] MinDataLen  = 3'd4;
    localparam logic [2:0] AckLen      = 3'd4;
    localparam logic [2:0] NumberEnd   = 3'd4;
    localparam logic [2:0] PosMax      = 3'd7;
    localparam logic [3:0] NetasciiLen = 4'd8;
    localparam logic [3:0] OctetLen    = 4'd5;
    localparam logic [3:0] ModeIdxMax  = 4'd15;

    // Characters of "netascii" by position.
    function automatic logic [7:0] netascii_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h6E; // n
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h63; // c
            3'd6:    c = 8'h69; // i
            default: c = 8'h69; // i
        endcase
        return c;
    endfunction

    // Characters of "octet" by position; positions past the end are never compared.
    function automatic logic [7:0] octet_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h6F; // o
            3'd1:    c = 8'h63; // c
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/tftpp_core.sv
// Per-byte parse logic and packet state of the TFTP packet parser.
module tftpp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  tftpp_pkg::t_in_word   i_word,
    output tftpp_pkg::t_out_word  o_word
);

    logic [2:0]          r_pos,     n_pos;
    tftpp_pkg::t_kind    r_kind,    n_kind;
    tftpp_pkg::t_section r_section, n_section;
    logic [15:0]         r_num,     n_num;
    logic [3:0]          r_idx,     n_idx;
    logic                r_na,      n_na;
    logic                r_oc,      n_oc;
    tftpp_pkg::t_status  r_err,     n_err;

    logic [7:0]         w_b;
    logic [7:0]         w_lc;
    logic               w_na_fin;
    logic               w_oc_fin;
    tftpp_pkg::t_role   w_role;
    tftpp_pkg::t_status w_status;
    logic               w_tmode;

    always_comb begin
        w_b       = i_word.byte_in;
        w_lc      = (w_b >= 8'h41 && w_b <= 8'h5A) ? (w_b + 8'd32) : w_b;
        w_na_fin  = r_na && (r_idx == tftpp_pkg::NetasciiLen);
        w_oc_fin  = r_oc && (r_idx == tftpp_pkg::OctetLen);
        n_kind    = r_kind;
        n_section = r_section;
        n_num     = r_num;
        n_idx     = r_idx;
        n_na      = r_na;
        n_oc      = r_oc;
        n_err     = r_err;
        w_role    = tftpp_pkg::ROLE_IGNORED;

        if (r_pos == 3'd0) begin
            w_role = tftpp_pkg::ROLE_OPCODE;
            if (w_b != 8'd0) begin
                n_err = tftpp_pkg::ST_BAD_OPCODE;
            end
        end else if (r_pos == 3'd1) begin
            w_role = tftpp_pkg::ROLE_OPCODE;
            if (w_b >= 8'd1 && w_b <= 8'd5) begin
                n_kind = tftpp_pkg::t_kind'(w_b[2:0]);
            end else begin
                n_kind = tftpp_pkg::KIND_UNKNOWN;
                n_err  = tftpp_pkg::ST_BAD_OPCODE;
            end
        end else begin
            unique case (r_kind)
                tftpp_pkg::KIND_RRQ, tftpp_pkg::KIND_WRQ: begin
                    unique case (r_section)
                        tftpp_pkg::SEC_FIRST: begin
                            if (w_b != 8'd0) begin
                                w_role = tftpp_pkg::ROLE_FILENAME;
                            end else begin
                                w_role    = tftpp_pkg::ROLE_TERM;
                                n_section = tftpp_pkg::SEC_MODE;
                            end
                        end
                        tftpp_pkg::SEC_MODE: begin
                            if (w_b != 8'd0) begin
                                w_role = tftpp_pkg::ROLE_MODE;
                                if (r_idx >= tftpp_pkg::NetasciiLen ||
                                    w_lc != tftpp_pkg::netascii_char(r_idx[2:0])) begin
                                    n_na = 1'b0;
                                end
                                if (r_idx >= tftpp_pkg::OctetLen ||
                                    w_lc != tftpp_pkg::octet_char(r_idx[2:0])) begin
                                    n_oc = 1'b0;
                                end
                                if (r_idx != tftpp_pkg::ModeIdxMax) begin
                                    n_idx = r_idx + 4'd1;
                                end
                            end else begin
                                // Mode ends: a match needs the full length too
                                w_role    = tftpp_pkg::ROLE_TERM;
                                n_na      = w_na_fin;
                                n_oc      = w_oc_fin;
                                n_section = tftpp_pkg::SEC_DONE;
                                if (!w_na_fin && !w_oc_fin && r_err == tftpp_pkg::ST_OK) begin
                                    n_err = tftpp_pkg::ST_MODE_UNKNOWN;
                                end
                            end
                        end
                        default: w_role = tftpp_pkg::ROLE_IGNORED;
                    endcase
                end
                tftpp_pkg::KIND_DATA: begin
                    w_role = (r_pos < tftpp_pkg::NumberEnd) ? tftpp_pkg::ROLE_NUMBER
                                                            : tftpp_pkg::ROLE_PAYLOAD;
                end
                tftpp_pkg::KIND_ACK: begin
                    w_role = (r_pos < tftpp_pkg::NumberEnd) ? tftpp_pkg::ROLE_NUMBER
                                                            : tftpp_pkg::ROLE_IGNORED;
                end
                tftpp_pkg::KIND_ERROR: begin
                    if (r_pos < tftpp_pkg::NumberEnd) begin
                        w_role = tftpp_pkg::ROLE_NUMBER;
                    end else if (r_section == tftpp_pkg::SEC_FIRST) begin
                        if (w_b != 8'd0) begin
                            w_role = tftpp_pkg::ROLE_MESSAGE;
                        end else begin
                            w_role    = tftpp_pkg::ROLE_TERM;
                            n_section = tftpp_pkg::SEC_DONE;
                        end
                    end else begin
                        w_role = tftpp_pkg::ROLE_IGNORED;
                    end
                end
                default: w_role = tftpp_pkg::ROLE_IGNORED;
            endcase
        end

        if (w_role == tftpp_pkg::ROLE_NUMBER) begin
            n_num = {r_num[7:0], w_b};
        end

        n_pos = (r_pos == tftpp_pkg::PosMax) ? tftpp_pkg::PosMax : (r_pos + 3'd1);

        // Final status on the closing byte, checked in priority order
        w_status = tftpp_pkg::ST_OK;
        if (i_word.last_byte) begin
            if (n_pos < 3'd2) begin
                w_status = tftpp_pkg::ST_TOO_SHORT;
            end else begin
                unique case (n_kind)
                    tftpp_pkg::KIND_RRQ, tftpp_pkg::KIND_WRQ: begin
                        priority if (n_pos < tftpp_pkg::MinReqLen) begin
                            w_status = tftpp_pkg::ST_TOO_SHORT;
                        end else if (n_err != tftpp_pkg::ST_OK) begin
                            w_status = n_err;
                        end else if (n_section == tftpp_pkg::SEC_FIRST) begin
                            w_status = tftpp_pkg::ST_FNAME_UNTERM;
                        end else if (n_section == tftpp_pkg::SEC_MODE) begin
                            w_status = tftpp_pkg::ST_MODE_UNTERM;
                        end else begin
                            w_status = tftpp_pkg::ST_OK;
                        end
                    end
                    tftpp_pkg::KIND_DATA: begin
                        w_status = (n_pos < tftpp_pkg::MinDataLen) ? tftpp_pkg::ST_TOO_SHORT
                                                                   : n_err;
                    end
                    tftpp_pkg::KIND_ACK: begin
                        w_status = (n_pos != tftpp_pkg::AckLen) ? tftpp_pkg::ST_ACK_LEN : n_err;
                    end
                    tftpp_pkg::KIND_ERROR: begin
                        priority if (n_pos < tftpp_pkg::MinErrLen) begin
                            w_status = tftpp_pkg::ST_TOO_SHORT;
                        end else if (n_err != tftpp_pkg::ST_OK) begin
                            w_status = n_err;
                        end else if (n_section == tftpp_pkg::SEC_FIRST) begin
                            w_status = tftpp_pkg::ST_MSG_UNTERM;
                        end else begin
                            w_status = tftpp_pkg::ST_OK;
                        end
                    end
                    default: w_status = tftpp_pkg::ST_BAD_OPCODE;
                endcase
            end
        end

        w_tmode = (n_kind == tftpp_pkg::KIND_RRQ || n_kind == tftpp_pkg::KIND_WRQ) &&
                  (n_section == tftpp_pkg::SEC_DONE) && n_oc;

        o_word.byte_out      = w_b;
        o_word.byte_role     = w_role;
        o_word.packet_kind   = n_kind;
        o_word.number_value  = n_num;
        o_word.transfer_mode = w_tmode;
        o_word.packet_done   = i_word.last_byte;
        o_word.status        = w_status;
    end

    // Return to the idle packet state after the closing byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_word.last_byte)) begin
            r_pos     <= 3'd0;
            r_kind    <= tftpp_pkg::KIND_UNKNOWN;
            r_section <= tftpp_pkg::SEC_FIRST;
            r_num     <= 16'd0;
            r_idx     <= 4'd0;
            r_na      <= 1'b1;
            r_oc      <= 1'b1;
            r_err     <= tftpp_pkg::ST_OK;
        end else if (i_adv) begin
            r_pos     <= n_pos;
            r_kind    <= n_kind;
            r_section <= n_section;
            r_num     <= n_num;
            r_idx     <= n_idx;
            r_na      <= n_na;
            r_oc      <= n_oc;
            r_err     <= n_err;
        end
    end

endmodule

FILE: rtl/tftp_packet_parser.sv
// Top level of the streaming TFTP packet parser: input register, parse core, result register.
// Path: a word is held in the input register, then parsed into the result register on advance.
// Throughput: one word per cycle unless stalled; a byte is parsed in one pass of tftpp_core.
// Back-pressure: o_in_ready falls only while both the input and result registers are full.
// Reset: i_rst_n is synchronous, active low; it empties both registers and returns the
// packet state to the start of a packet (mode matches armed, no error recorded).
module tftp_packet_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tftpp_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tftpp_pkg::t_out_word  o_out_word
);

    logic                 r_in_valid;
    tftpp_pkg::t_in_word  r_in_word;
    logic                 r_out_valid;
    tftpp_pkg::t_out_word r_out_word;

    logic                 w_adv;
    tftpp_pkg::t_out_word w_result;

    // Advance the held word into the result register when that register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Hold the incoming word; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Parse the held word against the packet state; the state moves only on advance
    tftpp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_word  (r_in_word),
        .o_word  (w_result)
    );

    // Result register: load on advance, drop once taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/tftpp_checker.sv
// Port-level assertions for the TFTP packet parser, bound to the top level.
module tftpp_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input tftpp_pkg::t_in_word   i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input tftpp_pkg::t_out_word  o_out_word
);

    // A waiting input word holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while waiting");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result changed while stalled");

    // Input stalls only when the result side is full and blocked
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with room downstream");

    // A status other than ok appears only on the closing byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.packet_done |-> o_out_word.status == tftpp_pkg::ST_OK)
        else $error("status before packet end");

    // Octet mode is reported only for requests, which carry no number
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.transfer_mode |->
            (o_out_word.packet_kind == tftpp_pkg::KIND_RRQ ||
             o_out_word.packet_kind == tftpp_pkg::KIND_WRQ) &&
            o_out_word.number_value == 16'd0)
        else $error("mode flag on a non-request");

endmodule

bind tftp_packet_parser tftpp_checker u_tftpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

FILE: dv/tftp_packet_parser_tb.sv
// Self-checking testbench for the TFTP packet parser: random and directed packets, byte by byte.
module tftp_packet_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real HalfPeriod  = 4.0;
    localparam int  ResetCycles = 7;
    localparam int  RandomBytes = 400;
    // Drain margin for a word still passing through the input and result registers.
    localparam int  DrainCycles = 8;
    // Longest honest quiet spell is a sender gap plus a receiver stall plus latency.
    localparam int  QuietLimit  = 200;

    localparam logic [2:0]  ReqMinLen   = 3'd6;
    localparam logic [2:0]  ErrMinLen   = 3'd5;
    localparam logic [2:0]  DataMinLen  = 3'd4;
    localparam logic [2:0]  AckWordLen  = 3'd4;
    localparam logic [2:0]  NumberLimit = 3'd4;
    localparam logic [2:0]  LenCeiling  = 3'd7;
    localparam logic [3:0]  ModeLenMax  = 4'd15;
    localparam logic [3:0]  NetasciiLen = 4'd8;
    localparam logic [3:0]  OctetLenTb  = 4'd5;
    localparam logic [63:0] NetasciiText = "netascii";
    localparam logic [39:0] OctetText    = "octet";

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    tftpp_pkg::t_in_word  i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    tftpp_pkg::t_out_word o_out_word;

    tftp_packet_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    always #(HalfPeriod) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Packet state as the parser should hold it between words
    // ------------------------------------------------------------------
    logic [2:0]          pos_q;          // bytes seen, saturating
    tftpp_pkg::t_kind    kind_q;
    tftpp_pkg::t_section sec_q;
    logic [15:0]         num_q;          // block number or error code, big-endian
    logic [3:0]          mode_len_q;     // mode characters seen, saturating
    logic                may_netascii;
    logic                may_octet;
    tftpp_pkg::t_status  err_q;          // first field error of the packet

    tftpp_pkg::t_in_word  pending[$];     // words still to be driven
    tftpp_pkg::t_out_word awaited[$];     // parsed words still to come out
    logic [7:0]           pkt[$];         // packet under construction
    int unsigned faults     = 0;
    int unsigned result_no  = 0;
    int unsigned quiet      = 0;
    int          in_gap     = 0;
    int          out_stall  = 0;
    bit          in_calm    = 1'b0;
    bit          out_calm   = 1'b0;
    logic        in_took    = 1'b0;
    logic        out_took   = 1'b0;

    // Arm the state for the start of a packet.
    function automatic void clear_packet();
        pos_q        = '0;
        kind_q       = tftpp_pkg::KIND_UNKNOWN;
        sec_q        = tftpp_pkg::SEC_FIRST;
        num_q        = '0;
        mode_len_q   = '0;
        may_netascii = 1'b1;
        may_octet    = 1'b1;
        err_q        = tftpp_pkg::ST_OK;
    endfunction

    // Advance the packet state by one byte and return the word it should produce.
    function automatic tftpp_pkg::t_out_word parse_byte(input tftpp_pkg::t_in_word w);
        logic [7:0]           b;
        logic [7:0]           lc;
        logic [2:0]           len;
        tftpp_pkg::t_role     role;
        tftpp_pkg::t_status   st;
        tftpp_pkg::t_out_word r;
        b    = w.byte_in;
        role = tftpp_pkg::ROLE_IGNORED;
        st   = tftpp_pkg::ST_OK;
        if (pos_q == 3'd0) begin
            role = tftpp_pkg::ROLE_OPCODE;
            if (b != 8'd0) err_q = tftpp_pkg::ST_BAD_OPCODE;
        end else if (pos_q == 3'd1) begin
            role = tftpp_pkg::ROLE_OPCODE;
            if (b >= 8'd1 && b <= 8'd5) begin
                kind_q = tftpp_pkg::t_kind'(b[2:0]);
            end else begin
                kind_q = tftpp_pkg::KIND_UNKNOWN;
                err_q  = tftpp_pkg::ST_BAD_OPCODE;
            end
        end else begin
            case (kind_q)
                tftpp_pkg::KIND_RRQ, tftpp_pkg::KIND_WRQ: begin
                    if (sec_q == tftpp_pkg::SEC_FIRST) begin
                        if (b != 8'd0) begin
                            role = tftpp_pkg::ROLE_FILENAME;
                        end else begin
                            role  = tftpp_pkg::ROLE_TERM;
                            sec_q = tftpp_pkg::SEC_MODE;
                        end
                    end else if (sec_q == tftpp_pkg::SEC_MODE) begin
                        if (b != 8'd0) begin
                            role = tftpp_pkg::ROLE_MODE;
                            // fold only A..Z
                            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                            if (mode_len_q >= NetasciiLen)
                                may_netascii = 1'b0;
                            else if (lc != NetasciiText[63 - 8*mode_len_q -: 8])
                                may_netascii = 1'b0;
                            if (mode_len_q >= OctetLenTb)
                                may_octet = 1'b0;
                            else if (lc != OctetText[39 - 8*mode_len_q -: 8])
                                may_octet = 1'b0;
                            if (mode_len_q < ModeLenMax) mode_len_q = mode_len_q + 4'd1;
                        end else begin
                            role         = tftpp_pkg::ROLE_TERM;
                            may_netascii = may_netascii && (mode_len_q == NetasciiLen);
                            may_octet    = may_octet && (mode_len_q == OctetLenTb);
                            if (!may_netascii && !may_octet && err_q == tftpp_pkg::ST_OK)
                                err_q = tftpp_pkg::ST_MODE_UNKNOWN;
                            sec_q = tftpp_pkg::SEC_DONE;
                        end
                    end
                end
                tftpp_pkg::KIND_DATA:
                    role = (pos_q < NumberLimit) ? tftpp_pkg::ROLE_NUMBER
                                                 : tftpp_pkg::ROLE_PAYLOAD;
                tftpp_pkg::KIND_ACK:
                    role = (pos_q < NumberLimit) ? tftpp_pkg::ROLE_NUMBER
                                                 : tftpp_pkg::ROLE_IGNORED;
                tftpp_pkg::KIND_ERROR: begin
                    if (pos_q < NumberLimit) begin
                        role = tftpp_pkg::ROLE_NUMBER;
                    end else if (sec_q == tftpp_pkg::SEC_FIRST) begin
                        if (b != 8'd0) begin
                            role = tftpp_pkg::ROLE_MESSAGE;
                        end else begin
                            role  = tftpp_pkg::ROLE_TERM;
                            sec_q = tftpp_pkg::SEC_DONE;
                        end
                    end
                end
                default: role = tftpp_pkg::ROLE_IGNORED;
            endcase
        end
        if (role == tftpp_pkg::ROLE_NUMBER) num_q = {num_q[7:0], b};

        len   = (pos_q < LenCeiling) ? pos_q + 3'd1 : LenCeiling;
        pos_q = len;

        // Status precedence: too short, then bad opcode, then the first field error.
        if (w.last_byte) begin
            if (len < 3'd2) begin
                st = tftpp_pkg::ST_TOO_SHORT;
            end else begin
                case (kind_q)
                    tftpp_pkg::KIND_RRQ, tftpp_pkg::KIND_WRQ: begin
                        if (len < ReqMinLen)                     st = tftpp_pkg::ST_TOO_SHORT;
                        else if (err_q != tftpp_pkg::ST_OK)      st = err_q;
                        else if (sec_q == tftpp_pkg::SEC_FIRST)  st = tftpp_pkg::ST_FNAME_UNTERM;
                        else if (sec_q == tftpp_pkg::SEC_MODE)   st = tftpp_pkg::ST_MODE_UNTERM;
                        else                                     st = tftpp_pkg::ST_OK;
                    end
                    tftpp_pkg::KIND_DATA:
                        st = (len < DataMinLen) ? tftpp_pkg::ST_TOO_SHORT : err_q;
                    // ACK length is judged before the opcode
                    tftpp_pkg::KIND_ACK:
                        st = (len != AckWordLen) ? tftpp_pkg::ST_ACK_LEN : err_q;
                    tftpp_pkg::KIND_ERROR: begin
                        if (len < ErrMinLen)                     st = tftpp_pkg::ST_TOO_SHORT;
                        else if (err_q != tftpp_pkg::ST_OK)      st = err_q;
                        else if (sec_q == tftpp_pkg::SEC_FIRST)  st = tftpp_pkg::ST_MSG_UNTERM;
                        else                                     st = tftpp_pkg::ST_OK;
                    end
                    default: st = tftpp_pkg::ST_BAD_OPCODE;
                endcase
            end
        end

        r.byte_out      = b;
        r.byte_role     = role;
        r.packet_kind   = kind_q;
        r.number_value  = num_q;
        r.transfer_mode = (kind_q == tftpp_pkg::KIND_RRQ || kind_q == tftpp_pkg::KIND_WRQ) &&
                          sec_q == tftpp_pkg::SEC_DONE && may_octet;
        r.packet_done   = w.last_byte;
        r.status        = st;
        if (w.last_byte) clear_packet();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------
    task automatic add(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) pkt.insert(pkt.size(), s[i]);
    endtask

    // Queue the packet as words, flagging its final byte.
    task automatic ship();
        tftpp_pkg::t_in_word w;
        foreach (pkt[i]) begin
            w.byte_in   = pkt[i];
            w.last_byte = (i == pkt.size() - 1);
            pending.insert(pending.size(), w);
        end
        pkt.delete();
    endtask

    task automatic add_random_text(input int n);
        repeat (n) pkt.insert(pkt.size(), 8'($urandom_range(1, 255)));
    endtask

    // Mode string: mostly the two known ones in random letter case, sometimes
    // near misses, empty, over-long, or with one character spoilt.
    task automatic add_mode();
        string      s;
        logic [7:0] c;
        int         spoil;
        int         pick;
        pick = $urandom_range(0, 7);
        if (pick < 3)       s = "netascii";
        else if (pick < 6)  s = "octet";
        else if (pick == 6) s = "";
        else begin
            case ($urandom_range(0, 3))
                0:       s = "octets";
                1:       s = "netasc";
                2:       s = "oct";
                default: s = "netasciinetascii+";
            endcase
        end
        spoil = (s.len() > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, s.len() - 1) : -1;
        foreach (s[i]) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
            if (i == spoil) c = 8'($urandom_range(1, 255));
            pkt.insert(pkt.size(), c);
        end
    endtask

    // One random packet, mostly well formed, sometimes cut short or pure noise.
    task automatic random_packet();
        int sel;
        int cut;
        sel = $urandom_range(0, 19);
        if (sel < 7) begin
            add(8'd0);
            add($urandom_range(0, 1) ? {5'd0, tftpp_pkg::KIND_RRQ} : {5'd0, tftpp_pkg::KIND_WRQ});
            add_random_text($urandom_range(0, 4));
            add(8'd0);
            add_mode();
            if ($urandom_range(0, 9) != 0) add(8'd0);
            if ($urandom_range(0, 3) == 0) add_random_text($urandom_range(1, 2));
        end else if (sel < 11) begin
            add(8'd0);
            add({5'd0, tftpp_pkg::KIND_DATA});
            add(8'($urandom_range(0, 255)));
            add(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 6)) add(8'($urandom_range(0, 255)));
        end else if (sel < 14) begin
            add(8'd0);
            add({5'd0, tftpp_pkg::KIND_ACK});
            add(8'($urandom_range(0, 255)));
            add(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) add(8'($urandom_range(0, 255)));
        end else if (sel < 18) begin
            add(8'd0);
            add({5'd0, tftpp_pkg::KIND_ERROR});
            add($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
            add(8'($urandom_range(0, 255)));
            add_random_text($urandom_range(0, 4));
            if ($urandom_range(0, 6) != 0) add(8'd0);
            if ($urandom_range(0, 3) == 0) add_random_text($urandom_range(1, 2));
        end else begin
            // noise: random opcode bytes, often a plausible first byte
            add($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) add(8'($urandom_range(0, 255)));
        end
        // truncate now and then, down to a single byte
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
        end
        ship();
    endtask

    // Gap or stall before the next word; calm stretches switch idling off for a while.
    task automatic draw_wait(inout bit calm, output int n);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        n = calm ? 0 : $urandom_range(0, 7);
    endtask

    task automatic report(input string msg);
        faults++;
        $display("tb: result %0d: %s", result_no, msg);
    endtask

    task automatic check_word(input tftpp_pkg::t_out_word got,
                              input tftpp_pkg::t_out_word want);
        if (got.byte_out !== want.byte_out)
            report($sformatf("byte_out %0d, want %0d", got.byte_out, want.byte_out));
        if (got.byte_role !== want.byte_role)
            report($sformatf("byte_role %0d, want %0d", got.byte_role, want.byte_role));
        if (got.packet_kind !== want.packet_kind)
            report($sformatf("packet_kind %0d, want %0d", got.packet_kind, want.packet_kind));
        if (got.number_value !== want.number_value)
            report($sformatf("number_value %0d, want %0d", got.number_value, want.number_value));
        if (got.transfer_mode !== want.transfer_mode)
            report($sformatf("transfer_mode %0d, want %0d", got.transfer_mode,
                             want.transfer_mode));
        if (got.packet_done !== want.packet_done)
            report($sformatf("packet_done %0d, want %0d", got.packet_done, want.packet_done));
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next word at the falling edge once the last one
    // was taken and its gap has run out; otherwise hold.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (in_took) draw_wait(in_calm, in_gap);
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                i_in_word  <= pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: drop ready for a drawn number of cycles after each word taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_took) draw_wait(out_calm, out_stall);
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every word taken in, check every word taken out,
    // and watch for the handshakes going quiet.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        tftpp_pkg::t_out_word want;
        in_took  <= i_rst_n && i_in_valid && o_in_ready;
        out_took <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) awaited.insert(awaited.size(), parse_byte(i_in_word));
            if (o_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    report($sformatf("word 0x%0h arrived with nothing awaited",
                                     o_out_word.byte_out));
                end else begin
                    want = awaited.pop_front();
                    check_word(o_out_word, want);
                end
                result_no++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QuietLimit) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int directed;
        clear_packet();

        // lone byte: too short
        add(8'h00); ship();
        // all-ones opcode and an out-of-range kind: bad opcode
        add(8'hFF); add(8'h09); ship();
        // ACK of five bytes with top block number: length wrong, fifth byte ignored
        add(8'h00); add({5'd0, tftpp_pkg::KIND_ACK}); add(8'hFF); add(8'hFF); add(8'h7F); ship();
        // shortest DATA, no payload
        add(8'h00); add({5'd0, tftpp_pkg::KIND_DATA}); add(8'h80); add(8'h01); ship();
        // ERROR with code zero and an empty message
        add(8'h00); add({5'd0, tftpp_pkg::KIND_ERROR}); add(8'h00); add(8'h00); add(8'h00);
        ship();
        // WRQ, mixed-case octet mode, one byte trailing after the mode terminator
        add(8'h00); add({5'd0, tftpp_pkg::KIND_WRQ}); add_text("f"); add(8'h00);
        add_text("OctEt"); add(8'h00); add_text("x"); ship();

        directed = pending.size();
        while (pending.size() < directed + RandomBytes) random_packet();

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every word is in and every parsed word is out
        while (pending.size() != 0 || i_in_valid || awaited.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        if (faults == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
